// ----- design/msixvt_pkg.sv -----
// MSI-X vector table controller: shared types and constants.
// Opcodes, status and word codes, register map, entry layout, FSM states.
// No dependencies.
`default_nettype none

package msixvt_pkg;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned VIU_W   = 7;
    localparam int unsigned ENT_W   = 94;

    localparam int unsigned ENT_DATA_LSB = 0;
    localparam int unsigned ENT_LO_LSB   = 32;
    localparam int unsigned ENT_HI_LSB   = 62;

    localparam logic [2:0] OP_TBL_RD = 3'd0;
    localparam logic [2:0] OP_TBL_WR = 3'd1;
    localparam logic [2:0] OP_PBA_RD = 3'd2;
    localparam logic [2:0] OP_PBA_WR = 3'd3;
    localparam logic [2:0] OP_EVENT  = 3'd4;
    localparam logic [2:0] OP_RESCAN = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic KIND_RESP = 1'b0;
    localparam logic KIND_MSG  = 1'b1;

    localparam logic [1:0] W_ADDR_LO = 2'd0;
    localparam logic [1:0] W_ADDR_HI = 2'd1;
    localparam logic [1:0] W_DATA    = 2'd2;
    localparam logic [1:0] W_CTRL    = 2'd3;

    localparam logic [1:0] REG_MSIX_EN   = 2'd0;
    localparam logic [1:0] REG_FUNC_MASK = 2'd1;
    localparam logic [1:0] REG_MEM_EN    = 2'd2;
    localparam logic [1:0] REG_VEC_USE   = 2'd3;

    localparam logic [VIU_W-1:0] VIU_RESET    = 7'd32;
    localparam logic [3:0]       ACCESS_BYTES = 4'd4;

    typedef struct packed {
        logic             msix_en;
        logic             func_mask;
        logic             mem_en;
        logic [VIU_W-1:0] vec_use;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_RESP,
        S_SCAN,
        S_MSG
    } t_state;

endpackage

`default_nettype wire

// ----- design/msix_vector_table_controller_top.sv -----
// MSI-X vector table and pending bit array controller, top level.
// Input channel (i_valid/o_stall) takes one access or event word; output channel
// (o_valid/i_stall) returns one response word, then one message word for each
// pending, unmasked vector in ascending order; o_last marks the final word.
// Configuration through a 32-bit APB port (registers at 0x0, 0x4, 0x8, 0xC).
// The response is formed in S_ACC and loaded into the output register from S_RESP,
// which waits while a stalled word still holds that register.
// A word that causes no messages visits only S_ACC and S_RESP; a scan then
// steps through the vectors in S_SCAN and sends each message from S_MSG.
// Entries live in one VECTORS-deep table RAM with a registered read port;
// table writes go through read-modify-write. Mask bits, pending bits and per
// entry valid bits sit in flip-flops.
// Reset (synchronous, active low) masks all vectors, clears pending bits,
// invalidates the entries so they read as zero, and restores the registers.
// A stalled output word holds; the block then waits before producing the next
// word, and o_stall stays high until the last word of the current input has
// been loaded into the output register.
// Depends on msixvt_pkg and msixvt_apb_regs.
`default_nettype none

module msix_vector_table_controller_top #(
    parameter int unsigned VECTORS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [msixvt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [2:0]                      i_opcode,
    input  wire logic [9:0]                      i_byte_offset,
    input  wire logic [3:0]                      i_access_bytes,
    input  wire logic [31:0]                     i_write_data,
    input  wire logic [5:0]                      i_vector,
    input  wire logic                            i_level,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_kind,
    output logic      [1:0]                      o_status,
    output logic      [31:0]                     o_read_data,
    output logic      [63:0]                     o_message_address,
    output logic      [31:0]                     o_message_data,
    output logic                                 o_last
);

    localparam int unsigned VW    = (VECTORS > 1) ? $clog2(VECTORS) : 1;
    localparam int unsigned EW    = msixvt_pkg::ENT_W;
    localparam int unsigned NW    = msixvt_pkg::VIU_W;
    localparam int unsigned HI    = msixvt_pkg::ENT_HI_LSB;
    localparam int unsigned LO    = msixvt_pkg::ENT_LO_LSB;
    localparam int unsigned DA    = msixvt_pkg::ENT_DATA_LSB;

    msixvt_pkg::t_cfg   cfg;
    msixvt_pkg::t_state r_state, n_state;

    logic [EW-1:0] mem [VECTORS];
    logic [EW-1:0] r_rd;
    logic          mem_re, mem_we;
    logic [VW-1:0] mem_ra, mem_wa;
    logic [EW-1:0] mem_wd;

    logic [VECTORS-1:0] r_pend, n_pend;
    logic [VECTORS-1:0] r_mask, n_mask;
    logic [VECTORS-1:0] r_vld, n_vld;
    logic [VECTORS-1:0] inrange, elig, elig_rest;

    logic [2:0]  r_op;
    logic [9:0]  r_off;
    logic [3:0]  r_len;
    logic [31:0] r_wdata;
    logic [5:0]  r_vec;
    logic        r_lvl;

    logic [1:0]    r_status, n_status;
    logic [31:0]   r_rdata, n_rdata;
    logic          r_do_scan, n_do_scan;
    logic [VW-1:0] r_v, n_v;
    logic          r_msg_last, n_msg_last;

    logic          r_ovalid;
    logic          r_okind;
    logic [1:0]    r_ostatus;
    logic [31:0]   r_ordata;
    logic [63:0]   r_omaddr;
    logic [31:0]   r_omdata;
    logic          r_olast;

    logic          load, ld_kind, ld_last;
    logic [1:0]    ld_status;
    logic [31:0]   ld_rdata, ld_mdata;
    logic [63:0]   ld_maddr;
    logic          out_free, accept;

    logic [NW-1:0] n_use;
    logic [VW-1:0] vidx, evidx;
    logic [1:0]    wsel;
    logic          bad, tbl_in, ev_in;
    logic [EW-1:0] entry, msg_ent;
    logic [7:0]    n_p31;
    logic [2:0]    dwords;
    logic [7:0]    pidx;
    logic [63:0]   pend64;

    msixvt_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // entries in use, saturated to 1..VECTORS
    always_comb begin
        priority if (cfg.vec_use == '0) begin
            n_use = NW'(1);
        end else if (cfg.vec_use > NW'(VECTORS)) begin
            n_use = NW'(VECTORS);
        end else begin
            n_use = cfg.vec_use;
        end
    end

    always_comb begin
        for (int i = 0; i < VECTORS; i++) begin
            inrange[i] = NW'(i) < n_use;
        end
        elig      = r_pend & ~r_mask & inrange & {VECTORS{~cfg.func_mask}};
        elig_rest = elig;
        elig_rest[r_v] = 1'b0;
    end

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != msixvt_pkg::S_IDLE);
    assign out_free = !r_ovalid || !i_stall;

    assign vidx    = r_off[4 +: VW];
    assign evidx   = r_vec[VW-1:0];
    assign wsel    = r_off[3:2];
    assign bad     = (r_len != msixvt_pkg::ACCESS_BYTES) || (r_off[1:0] != 2'b00);
    assign tbl_in  = {1'b0, r_off[9:4]} < n_use;
    assign ev_in   = {1'b0, r_vec} < n_use;
    assign entry   = r_vld[vidx] ? r_rd : '0;
    assign msg_ent = r_vld[r_v] ? r_rd : '0;
    assign n_p31   = {1'b0, n_use} + 8'd31;
    assign dwords  = n_p31[7:5];
    assign pidx    = r_off[9:2];
    assign pend64  = 64'(r_pend);

    // table RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_mask     = r_mask;
        n_vld      = r_vld;
        n_status   = r_status;
        n_rdata    = r_rdata;
        n_do_scan  = r_do_scan;
        n_v        = r_v;
        n_msg_last = r_msg_last;
        mem_re     = 1'b0;
        mem_ra     = r_v;
        mem_we     = 1'b0;
        mem_wa     = vidx;
        mem_wd     = entry;
        load       = 1'b0;
        ld_kind    = msixvt_pkg::KIND_RESP;
        ld_status  = msixvt_pkg::ST_OK;
        ld_rdata   = 32'd0;
        ld_maddr   = 64'd0;
        ld_mdata   = 32'd0;
        ld_last    = 1'b0;

        unique case (r_state)
            msixvt_pkg::S_IDLE: begin
                if (i_valid) begin
                    mem_re  = 1'b1;
                    mem_ra  = i_byte_offset[4 +: VW];
                    n_state = msixvt_pkg::S_ACC;
                end
            end
            msixvt_pkg::S_ACC: begin
                n_status  = msixvt_pkg::ST_OK;
                n_rdata   = 32'd0;
                n_do_scan = 1'b0;
                n_state   = msixvt_pkg::S_RESP;
                priority if (r_op <= msixvt_pkg::OP_PBA_WR && bad) begin
                    n_status = msixvt_pkg::ST_BAD;
                end else if (r_op == msixvt_pkg::OP_TBL_RD || r_op == msixvt_pkg::OP_TBL_WR) begin
                    if (!tbl_in) begin
                        n_status = msixvt_pkg::ST_RANGE;
                    end else if (r_op == msixvt_pkg::OP_TBL_RD) begin
                        unique case (wsel)
                            msixvt_pkg::W_ADDR_LO: n_rdata = {entry[LO +: 30], 2'b00};
                            msixvt_pkg::W_ADDR_HI: n_rdata = entry[HI +: 32];
                            msixvt_pkg::W_DATA:    n_rdata = entry[DA +: 32];
                            msixvt_pkg::W_CTRL:    n_rdata = {31'd0, r_mask[vidx]};
                            default:               n_rdata = 32'd0;
                        endcase
                    end else begin
                        n_do_scan = 1'b1;
                        unique case (wsel)
                            msixvt_pkg::W_ADDR_LO: mem_wd[LO +: 30] = r_wdata[31:2];
                            msixvt_pkg::W_ADDR_HI: mem_wd[HI +: 32] = r_wdata;
                            msixvt_pkg::W_DATA:    mem_wd[DA +: 32] = r_wdata;
                            msixvt_pkg::W_CTRL:    n_mask[vidx]     = r_wdata[0];
                            default: ;
                        endcase
                        if (wsel != msixvt_pkg::W_CTRL) begin
                            mem_we      = 1'b1;
                            n_vld[vidx] = 1'b1;
                        end
                    end
                end else if (r_op == msixvt_pkg::OP_PBA_RD) begin
                    if (pidx < {5'd0, dwords}) begin
                        n_rdata = pidx[0] ? pend64[63:32] : pend64[31:0];
                    end else begin
                        n_status = msixvt_pkg::ST_RANGE;
                    end
                end else if (r_op == msixvt_pkg::OP_EVENT) begin
                    if (cfg.msix_en && cfg.mem_en) begin
                        if (!ev_in) begin
                            n_status = msixvt_pkg::ST_RANGE;
                        end else if (r_lvl) begin
                            n_pend[evidx] = 1'b1;
                            n_do_scan     = !r_mask[evidx] && !cfg.func_mask;
                        end else begin
                            n_pend[evidx] = 1'b0;
                        end
                    end
                end else if (r_op == msixvt_pkg::OP_RESCAN) begin
                    n_do_scan = 1'b1;
                end else begin
                    n_status = msixvt_pkg::ST_OK;
                end
            end
            msixvt_pkg::S_RESP: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld_status = r_status;
                    ld_rdata  = r_rdata;
                    ld_last   = !(r_do_scan && (elig != '0));
                    n_v       = '0;
                    n_state   = ld_last ? msixvt_pkg::S_IDLE : msixvt_pkg::S_SCAN;
                end
            end
            msixvt_pkg::S_SCAN: begin
                if (elig[r_v]) begin
                    mem_re         = 1'b1;
                    mem_ra         = r_v;
                    n_pend[r_v]    = 1'b0;
                    n_msg_last     = (elig_rest == '0);
                    n_state        = msixvt_pkg::S_MSG;
                end else begin
                    n_v = r_v + VW'(1);
                end
            end
            msixvt_pkg::S_MSG: begin
                if (out_free) begin
                    load     = 1'b1;
                    ld_kind  = msixvt_pkg::KIND_MSG;
                    ld_maddr = {msg_ent[HI +: 32], msg_ent[LO +: 30], 2'b00};
                    ld_mdata = msg_ent[DA +: 32];
                    ld_last  = r_msg_last;
                    if (r_msg_last) begin
                        n_state = msixvt_pkg::S_IDLE;
                    end else begin
                        n_v     = r_v + VW'(1);
                        n_state = msixvt_pkg::S_SCAN;
                    end
                end
            end
            default: n_state = msixvt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msixvt_pkg::S_IDLE;
            r_pend   <= '0;
            r_mask   <= '1;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_mask  <= n_mask;
            r_vld   <= n_vld;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_opcode;
            r_off   <= i_byte_offset;
            r_len   <= i_access_bytes;
            r_wdata <= i_write_data;
            r_vec   <= i_vector;
            r_lvl   <= i_level;
        end
        r_status   <= n_status;
        r_rdata    <= n_rdata;
        r_do_scan  <= n_do_scan;
        r_v        <= n_v;
        r_msg_last <= n_msg_last;
        if (load) begin
            r_okind   <= ld_kind;
            r_ostatus <= ld_status;
            r_ordata  <= ld_rdata;
            r_omaddr  <= ld_maddr;
            r_omdata  <= ld_mdata;
            r_olast   <= ld_last;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_kind            = r_okind;
    assign o_status          = r_ostatus;
    assign o_read_data       = r_ordata;
    assign o_message_address = r_omaddr;
    assign o_message_data    = r_omdata;
    assign o_last            = r_olast;

endmodule

`default_nettype wire

// ----- design/msixvt_apb_regs.sv -----
// MSI-X vector table controller: APB configuration registers.
// Holds enable, function mask, memory enable and vectors-in-use.
// Depends on msixvt_pkg.
`default_nettype none

module msixvt_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msixvt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output msixvt_pkg::t_cfg                   o_cfg
);

    msixvt_pkg::t_cfg r_cfg;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msix_en   <= 1'b0;
            r_cfg.func_mask <= 1'b0;
            r_cfg.mem_en    <= 1'b0;
            r_cfg.vec_use   <= msixvt_pkg::VIU_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                msixvt_pkg::REG_MSIX_EN:   r_cfg.msix_en   <= pwdata[0];
                msixvt_pkg::REG_FUNC_MASK: r_cfg.func_mask <= pwdata[0];
                msixvt_pkg::REG_MEM_EN:    r_cfg.mem_en    <= pwdata[0];
                msixvt_pkg::REG_VEC_USE:   r_cfg.vec_use   <= pwdata[msixvt_pkg::VIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            msixvt_pkg::REG_MSIX_EN:   prdata = {31'd0, r_cfg.msix_en};
            msixvt_pkg::REG_FUNC_MASK: prdata = {31'd0, r_cfg.func_mask};
            msixvt_pkg::REG_MEM_EN:    prdata = {31'd0, r_cfg.mem_en};
            msixvt_pkg::REG_VEC_USE:   prdata = {25'd0, r_cfg.vec_use};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/msixvt_chk.sv -----
// MSI-X vector table controller: port-level checker and its bind.
// Watches the input and output channels of the top level.
// Depends on msixvt_pkg and msix_vector_table_controller_top.
`default_nettype none

module msixvt_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_kind,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_read_data,
    input wire logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_status)
            && $stable(o_read_data) && $stable(o_last))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again before response");

    a_msg_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == msixvt_pkg::KIND_MSG |->
            o_status == msixvt_pkg::ST_OK && o_read_data == 32'd0)
        else $error("message word with status or read data");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == msixvt_pkg::KIND_RESP && o_status != msixvt_pkg::ST_OK
            |-> o_last)
        else $error("failed access followed by messages");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind msix_vector_table_controller_top msixvt_chk u_msixvt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_kind      (o_kind),
    .o_status    (o_status),
    .o_read_data (o_read_data),
    .o_last      (o_last)
);

`default_nettype wire

// ----- tb/msix_tb_pkg.sv -----
`timescale 1ns / 1ps
// Word types and the vector table tracker for the MSI-X controller testbench.
// The tracker predicts the response and message words of each accepted word.
// Depends on msixvt_pkg.

package msix_tb_pkg;

    localparam int unsigned TB_VECTORS = 32;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  offset;
        logic [3:0]  len;
        logic [31:0] write_data;
        logic [5:0]  vector;
        logic        level;
    } t_access_word;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [63:0] msg_addr;
        logic [31:0] msg_data;
        logic        last;
    } t_out_word;

    class msix_table_tracker;
        msixvt_pkg::t_cfg      cfg;
        logic [63:0]           tbl_addr [TB_VECTORS];
        logic [31:0]           tbl_data [TB_VECTORS];
        logic                  tbl_mask [TB_VECTORS];
        logic [TB_VECTORS-1:0] pend_bits;
        t_out_word             expected_words [$];
        int unsigned           errors;

        function new();
            cfg.msix_en   = 1'b0;
            cfg.func_mask = 1'b0;
            cfg.mem_en    = 1'b0;
            cfg.vec_use   = msixvt_pkg::VIU_RESET;
            for (int unsigned i = 0; i < TB_VECTORS; i++) begin
                tbl_addr[i] = '0;
                tbl_data[i] = '0;
                tbl_mask[i] = 1'b1;
            end
            pend_bits = '0;
            errors    = 0;
        endfunction

        function int unsigned in_use();
            if (cfg.vec_use == 0) return 1;
            if (cfg.vec_use > TB_VECTORS) return TB_VECTORS;
            return cfg.vec_use;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] word);
            case (idx)
                msixvt_pkg::REG_MSIX_EN:   cfg.msix_en   = word[0];
                msixvt_pkg::REG_FUNC_MASK: cfg.func_mask = word[0];
                msixvt_pkg::REG_MEM_EN:    cfg.mem_en    = word[0];
                default:                   cfg.vec_use   = word[msixvt_pkg::VIU_W-1:0];
            endcase
        endfunction

        function void queue_word(t_out_word w);
            expected_words = {expected_words, w};
        endfunction

        function void note_word(t_access_word w);
            int unsigned n;
            int unsigned v;
            int unsigned i;
            logic [1:0]  sel;
            logic [1:0]  st;
            logic [31:0] rd;
            logic        bad;
            logic        scan;
            t_out_word   prev;
            n    = in_use();
            v    = w.offset[9:4];
            sel  = w.offset[3:2];
            bad  = (w.len != msixvt_pkg::ACCESS_BYTES) || (w.offset[1:0] != 2'b00);
            st   = msixvt_pkg::ST_OK;
            rd   = '0;
            scan = 1'b0;
            if (w.opcode <= msixvt_pkg::OP_PBA_WR && bad) begin
                st = msixvt_pkg::ST_BAD;
            end else if (w.opcode == msixvt_pkg::OP_TBL_RD ||
                         w.opcode == msixvt_pkg::OP_TBL_WR) begin
                if (v >= n) begin
                    st = msixvt_pkg::ST_RANGE;
                end else if (w.opcode == msixvt_pkg::OP_TBL_RD) begin
                    case (sel)
                        msixvt_pkg::W_ADDR_LO: rd = tbl_addr[v][31:0];
                        msixvt_pkg::W_ADDR_HI: rd = tbl_addr[v][63:32];
                        msixvt_pkg::W_DATA:    rd = tbl_data[v];
                        default:               rd = {31'b0, tbl_mask[v]};
                    endcase
                end else begin
                    case (sel)
                        msixvt_pkg::W_ADDR_LO:
                            tbl_addr[v][31:0] = {w.write_data[31:2], 2'b00};
                        msixvt_pkg::W_ADDR_HI: tbl_addr[v][63:32] = w.write_data;
                        msixvt_pkg::W_DATA:    tbl_data[v]        = w.write_data;
                        default:               tbl_mask[v]        = w.write_data[0];
                    endcase
                    scan = 1'b1;
                end
            end else if (w.opcode == msixvt_pkg::OP_PBA_RD) begin
                if (w.offset[9:2] >= (n + 31) / 32) st = msixvt_pkg::ST_RANGE;
                else rd = pend_bits;
            end else if (w.opcode == msixvt_pkg::OP_EVENT) begin
                if (cfg.msix_en && cfg.mem_en) begin
                    if (w.vector >= n) begin
                        st = msixvt_pkg::ST_RANGE;
                    end else if (w.level) begin
                        pend_bits[w.vector] = 1'b1;
                        scan = !tbl_mask[w.vector] && !cfg.func_mask;
                    end else begin
                        pend_bits[w.vector] = 1'b0;
                    end
                end
            end else if (w.opcode == msixvt_pkg::OP_RESCAN) begin
                scan = 1'b1;
            end

            prev           = '0;
            prev.kind      = msixvt_pkg::KIND_RESP;
            prev.status    = st;
            prev.read_data = rd;
            if (scan) begin
                for (i = 0; i < n; i++) begin
                    if (pend_bits[i] && !tbl_mask[i] && !cfg.func_mask) begin
                        pend_bits[i] = 1'b0;
                        queue_word(prev);
                        prev          = '0;
                        prev.kind     = msixvt_pkg::KIND_MSG;
                        prev.status   = msixvt_pkg::ST_OK;
                        prev.msg_addr = tbl_addr[i];
                        prev.msg_data = tbl_data[i];
                    end
                end
            end
            prev.last = 1'b1;
            queue_word(prev);
        endfunction

        task report(string msg);
            if (errors < 100) $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("output word with nothing expected: kind=%0d status=%0d",
                                 got.kind, got.status));
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
                report($sformatf("exp %0d/%0d/%h/%h/%h/%0d got %0d/%0d/%h/%h/%h/%0d",
                                 want.kind, want.status, want.read_data, want.msg_addr,
                                 want.msg_data, want.last, got.kind, got.status,
                                 got.read_data, got.msg_addr, got.msg_data, got.last));
        endtask
    endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the MSI-X vector table controller: clock, reset, APB setup,
// word driver with random gaps, output stall generator, checker and watchdog.
// Depends on msixvt_pkg, msix_tb_pkg and msix_vector_table_controller_top.

module testbench;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 8;

    localparam logic [3:0] LEN_OK     = msixvt_pkg::ACCESS_BYTES;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [msixvt_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                    pwdata  = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    msix_tb_pkg::t_access_word      in_word = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic                           o_kind;
    logic [1:0]                     o_status;
    logic [31:0]                    o_read_data;
    logic [63:0]                    o_message_address;
    logic [31:0]                    o_message_data;
    logic                           o_last;

    msix_tb_pkg::msix_table_tracker model;
    bit                gaps_on   = 1'b1;
    bit                hold_tgl  = 1'b0;
    bit                hold_seen = 1'b0;
    int unsigned       hold_left  = 0;
    int unsigned       burst_left = 0;
    int unsigned       quiet_cycles = 0;

    msix_vector_table_controller_top #(
        .VECTORS(msix_tb_pkg::TB_VECTORS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (in_word.opcode),
        .i_byte_offset     (in_word.offset),
        .i_access_bytes    (in_word.len),
        .i_write_data      (in_word.write_data),
        .i_vector          (in_word.vector),
        .i_level           (in_word.level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_status          (o_status),
        .o_read_data       (o_read_data),
        .o_message_address (o_message_address),
        .o_message_data    (o_message_data),
        .o_last            (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // output stall: random bursts, or one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen = hold_tgl;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!gaps_on) begin
            i_stall <= 1'b0;
        end else if (burst_left != 0) begin
            burst_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall <= 1'b1;
            burst_left = $urandom_range(0, 10);
        end else begin
            i_stall <= 1'b0;
            burst_left = $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            model.check_word({o_kind, o_status, o_read_data, o_message_address,
                              o_message_data, o_last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic msix_tb_pkg::t_access_word mk(logic [2:0] op, logic [9:0] offset,
                                                     logic [3:0] len, logic [31:0] wdata,
                                                     logic [5:0] vec, logic lvl);
        msix_tb_pkg::t_access_word w;
        w.opcode     = op;
        w.offset     = offset;
        w.len        = len;
        w.write_data = wdata;
        w.vector     = vec;
        w.level      = lvl;
        return w;
    endfunction

    // mostly well-formed accesses and events on vectors in use, the rest noise
    function automatic msix_tb_pkg::t_access_word random_word();
        msix_tb_pkg::t_access_word w;
        int unsigned  n;
        int unsigned  pick;
        logic [5:0]   v;
        logic [1:0]   sel;
        n            = model.in_use();
        w.opcode     = 3'($urandom_range(0, 7));
        w.offset     = 10'($urandom_range(0, 1023));
        w.len        = 4'($urandom_range(0, 15));
        w.write_data = $urandom();
        w.vector     = 6'($urandom_range(0, 63));
        w.level      = 1'($urandom_range(0, 1));
        v            = 6'($urandom_range(0, n - 1));
        sel          = 2'($urandom_range(0, 3));
        pick         = $urandom_range(0, 99);
        if (pick < 80) begin
            w.len         = LEN_OK;
            w.offset[1:0] = 2'b00;
        end
        if (pick < 25) begin
            w.opcode = msixvt_pkg::OP_EVENT;
            if ($urandom_range(0, 9) != 0) w.vector = v;
            w.level = ($urandom_range(0, 4) != 0);
        end else if (pick < 50) begin
            w.opcode = msixvt_pkg::OP_TBL_WR;
            w.offset = {v, sel, 2'b00};
            if (sel == msixvt_pkg::W_CTRL) w.write_data[0] = ($urandom_range(0, 2) == 0);
        end else if (pick < 62) begin
            w.opcode = msixvt_pkg::OP_TBL_RD;
            w.offset = {v, sel, 2'b00};
        end else if (pick < 68) begin
            w.opcode = ($urandom_range(0, 2) == 0) ? msixvt_pkg::OP_PBA_WR
                                                   : msixvt_pkg::OP_PBA_RD;
            if ($urandom_range(0, 3) != 0) w.offset = 10'd0;
        end else if (pick < 80) begin
            w.opcode = msixvt_pkg::OP_RESCAN;
        end
        return w;
    endfunction

    task automatic send_word(msix_tb_pkg::t_access_word w);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        model.note_word(w);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (model.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] word;
        word = $urandom();
        if (idx == msixvt_pkg::REG_VEC_USE)
            word = {word[31:msixvt_pkg::VIU_W], val[msixvt_pkg::VIU_W-1:0]};
        else
            word = {word[31:1], val[0]};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        model.set_reg(idx, word);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic msix_en, logic func_mask, logic mem_en,
                             logic [msixvt_pkg::VIU_W-1:0] vec_use);
        idle_input();
        drain();
        apb_write(msixvt_pkg::REG_MSIX_EN, {31'b0, msix_en});
        apb_write(msixvt_pkg::REG_FUNC_MASK, {31'b0, func_mask});
        apb_write(msixvt_pkg::REG_MEM_EN, {31'b0, mem_en});
        apb_write(msixvt_pkg::REG_VEC_USE, {25'b0, vec_use});
    endtask

    // starts with a rescan so pending vectors released by the new setting go out
    task automatic run_phase(int unsigned count, bit gaps, bit hold);
        int unsigned  taken;
        msix_tb_pkg::t_access_word w;
        @(posedge i_clk);
        gaps_on = gaps;
        if (hold) hold_tgl = ~hold_tgl;
        send_word(mk(msixvt_pkg::OP_RESCAN, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b0));
        taken = 0;
        while (taken < count) begin
            w = random_word();
            taken++;
            send_word(w);
        end
    endtask

    initial begin
        model = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: events disabled, all vectors masked
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd3, 1'b1));
        send_word(mk(msixvt_pkg::OP_TBL_RD, 10'h00c, LEN_OK, 32'd0, 6'd0, 1'b0));

        configure(1'b1, 1'b0, 1'b1, 7'd32);
        send_word(mk(msixvt_pkg::OP_TBL_WR, 10'h000, LEN_OK, 32'hffff_ffff, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_WR, 10'h004, LEN_OK, 32'hffff_ffff, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_WR, 10'h008, LEN_OK, 32'hffff_ffff, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b1));
        send_word(mk(msixvt_pkg::OP_PBA_RD, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_WR, 10'h00c, LEN_OK, 32'hffff_fffe, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_RD, 10'h000, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_RD, 10'h00c, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd63, 1'b1));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd32, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_RD, 10'h200, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_RD, 10'h3fc, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_RD, 10'h000, 4'd8, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_WR, 10'h002, LEN_OK, 32'h1234_5678, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_PBA_RD, 10'h004, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_PBA_WR, 10'd0, LEN_OK, 32'hffff_ffff, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_PBA_RD, 10'd0, 4'd15, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_TBL_WR, 10'h1fc, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd31, 1'b1));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd5, 1'b1));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd5, 1'b0));
        send_word(mk(msixvt_pkg::OP_RESCAN, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(OP_SPARE_A, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(OP_SPARE_B, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b0));
        send_word(mk(msixvt_pkg::OP_EVENT, 10'd0, LEN_OK, 32'd0, 6'd0, 1'b1));

        run_phase(55, 1'b1, 1'b0);
        configure(1'b1, 1'b1, 1'b1, 7'd32);
        run_phase(45, 1'b1, 1'b0);
        configure(1'b1, 1'b0, 1'b1, 7'd32);
        run_phase(35, 1'b1, 1'b0);
        configure(1'b1, 1'b0, 1'b1, 7'd1);
        run_phase(35, 1'b1, 1'b0);
        configure(1'b0, 1'b0, 1'b1, 7'd64);
        run_phase(20, 1'b1, 1'b0);
        configure(1'b1, 1'b1, 1'b0, 7'd127);
        run_phase(20, 1'b1, 1'b0);
        configure(1'b1, 1'b0, 1'b1, 7'd0);
        run_phase(25, 1'b1, 1'b0);
        configure(1'b1, 1'b0, 1'b1, 7'd5);
        run_phase(35, 1'b1, 1'b0);
        configure(1'b1, 1'b0, 1'b1, 7'd32);
        run_phase(40, 1'b0, 1'b1);
        configure(1'b1, 1'b0, 1'b1, 7'd17);
        run_phase(55, 1'b0, 1'b0);

        idle_input();
        drain();
        repeat (20) @(posedge i_clk);
        if (model.errors == 0 && model.expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
